// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define DVRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle, consequent in the next one.
`define DVRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/dvrt_pkg.sv -----
// Types, codes and helper functions of the distance-vector route table.
package dvrt_pkg;

    localparam logic [31:0] UNREACHABLE = 32'hFFFF_FFFF;
    localparam logic [7:0]  AGE_MAX = 8'hFF;
    localparam logic [7:0]  AGE_LIMIT_RESET = 8'd5;

    typedef enum logic [2:0] {
        REQ_LOAD = 3'd0,
        REQ_ADV  = 3'd1,
        REQ_LOST = 3'd2,
        REQ_AGE  = 3'd3,
        REQ_READ = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        ST_LOADED   = 4'd0,
        ST_IGNORED  = 4'd1,
        ST_UPDATED  = 4'd2,
        ST_KEPT     = 4'd3,
        ST_INSERTED = 4'd4,
        ST_FULL     = 4'd5,
        ST_READ_OK  = 4'd6,
        ST_BAD_IDX  = 4'd7,
        ST_LOST     = 4'd8,
        ST_AGED     = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  len;
        logic [31:0] distance;
        logic [31:0] nexthop;
        logic        direct;
        logic [7:0]  age;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic scan_issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic scan_last;
        logic stop;
        logic out_free;
    } stat_t;

    // Network mask from a prefix length; zero length gives an empty mask.
    function automatic logic [31:0] len_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0)
            m = 32'd0;
        else if (len >= 6'd32)
            m = UNREACHABLE;
        else
            m = UNREACHABLE << (6'd32 - len);
        return m;
    endfunction

endpackage

// ----- hw/rtl/dvrt_if.sv -----
// Channel interfaces: request, response and configuration write.
interface dvrt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] net_prefix;
    logic [5:0]  prefix_len;
    logic [31:0] route_distance;
    logic [31:0] via_addr;
    logic [4:0]  entry_index;
    modport source (output valid, req_type, net_prefix, prefix_len, route_distance,
                    via_addr, entry_index, input ready);
    modport sink (input valid, req_type, net_prefix, prefix_len, route_distance,
                  via_addr, entry_index, output ready);
endinterface

interface dvrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [4:0]  slot;
    logic [31:0] out_prefix;
    logic [5:0]  out_len;
    logic [31:0] out_distance;
    logic [31:0] out_via;
    logic        out_direct;
    logic [5:0]  entry_total;
    modport source (output valid, status, slot, out_prefix, out_len, out_distance,
                    out_via, out_direct, entry_total, input ready);
    modport sink (input valid, status, slot, out_prefix, out_len, out_distance,
                  out_via, out_direct, entry_total, output ready);
endinterface

interface dvrt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] age_limit;
    modport source (output valid, age_limit, input ready);
    modport sink (input valid, age_limit, output ready);
endinterface

// ----- hw/rtl/dvrt_ctrl.sv -----
// Sequencer of the route table: accepts a request, runs the scan, hands off the result.
module dvrt_ctrl
    import dvrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic [2:0] req_type,
    output logic       req_ready,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if ((req_type == REQ_ADV || req_type == REQ_LOST ||
                         req_type == REQ_AGE) && !stat.cnt_zero)
                        state_next = S_SCAN;
                    else
                        state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (stat.stop)
                    state_next = S_DRAIN;
                else
                begin
                    cmd.scan_issue = 1'b1;
                    if (stat.scan_last)
                        state_next = S_DRAIN;
                end
            end
            S_DRAIN:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/dvrt_path.sv -----
// Datapath of the route table: entry memory, scan pipeline, counters and result register.
module dvrt_path
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    dvrt_req_if.sink   req,
    dvrt_rsp_if.source rsp,
    dvrt_cfg_if.sink   cfg,
    input  cmd_t       cmd,
    output stat_t      stat
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    req_t        rq_type_reg;
    logic [31:0] rq_pfx_reg;
    logic [5:0]  rq_len_reg;
    logic [31:0] rq_dist_reg;
    logic [31:0] rq_via_reg;
    logic [4:0]  rq_idx_reg;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             p_vld_reg;
    logic [IDX_W-1:0] p_idx_reg;
    logic             stop_reg;
    logic [IDX_W-1:0] stop_slot_reg;
    logic             lrn_found_reg;
    logic [IDX_W-1:0] lrn_slot_reg;
    entry_t           lrn_entry_reg;
    logic [7:0]       age_limit_reg;

    logic        out_valid_reg;
    status_t     o_status_reg, o_status;
    logic [4:0]  o_slot_reg, o_slot;
    entry_t      o_entry_reg, o_entry;

    logic             rd_en, we;
    logic [IDX_W-1:0] rd_addr, wa;
    entry_t           wd, new_entry, e;
    logic             proc, stop_set, lrn_set, full;
    logic [31:0]      net;
    logic [7:0]       age_inc;

    assign e = rd_data_reg;
    assign proc = p_vld_reg && !stop_reg;
    assign net = rq_via_reg & len_mask(rq_len_reg);
    assign full = count_reg >= CNT_W'(TABLE_DEPTH);
    assign age_inc = (e.age == AGE_MAX) ? AGE_MAX : e.age + 8'd1;

    assign stat.cnt_zero = (count_reg == '0);
    assign stat.scan_last = (idx_reg == count_reg - CNT_W'(1));
    assign stat.stop = stop_reg;
    assign stat.out_free = !out_valid_reg || rsp.ready;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        new_entry.prefix = rq_pfx_reg;
        new_entry.len = rq_len_reg;
        new_entry.distance = rq_dist_reg;
        new_entry.nexthop = rq_via_reg;
        new_entry.direct = (rq_type_reg == REQ_LOAD);
        new_entry.age = 8'd0;

        rd_en = 1'b0;
        rd_addr = '0;
        we = 1'b0;
        wa = p_idx_reg;
        wd = e;
        stop_set = 1'b0;
        lrn_set = 1'b0;
        o_status = ST_IGNORED;
        o_slot = 5'd0;
        o_entry = '0;
        count_next = count_reg;

        if (cmd.accept)
        begin
            rd_en = 1'b1;
            rd_addr = IDX_W'(req.entry_index);
        end
        else if (cmd.scan_issue)
        begin
            rd_en = 1'b1;
            rd_addr = idx_reg[IDX_W-1:0];
        end

        if (proc)
        begin
            unique case (rq_type_reg)
                REQ_ADV:
                begin
                    if (e.direct)
                    begin
                        if (e.prefix == net)
                        begin
                            we = 1'b1;
                            wd.age = 8'd0;
                        end
                        if (e.prefix == rq_pfx_reg && e.len == rq_len_reg)
                            stop_set = 1'b1;
                    end
                    else if (!lrn_found_reg && e.prefix == rq_pfx_reg &&
                             e.len == rq_len_reg)
                        lrn_set = 1'b1;
                end
                REQ_LOST:
                begin
                    if (rq_pfx_reg == (e.nexthop & len_mask(e.len)))
                    begin
                        we = 1'b1;
                        wd.distance = UNREACHABLE;
                    end
                end
                REQ_AGE:
                begin
                    we = 1'b1;
                    wd.age = age_inc;
                    if (age_inc >= age_limit_reg)
                        wd.distance = UNREACHABLE;
                end
                default:
                    we = 1'b0;
            endcase
        end

        if (cmd.finish)
        begin
            unique case (rq_type_reg)
                REQ_LOAD, REQ_ADV:
                begin
                    if (rq_type_reg == REQ_ADV && stop_reg)
                    begin
                        o_status = ST_IGNORED;
                        o_slot = 5'(stop_slot_reg);
                    end
                    else if (rq_type_reg == REQ_ADV && lrn_found_reg)
                    begin
                        we = 1'b1;
                        wa = lrn_slot_reg;
                        wd = lrn_entry_reg;
                        wd.age = 8'd0;
                        o_slot = 5'(lrn_slot_reg);
                        if (rq_dist_reg < lrn_entry_reg.distance ||
                            rq_via_reg == lrn_entry_reg.nexthop)
                        begin
                            wd.distance = rq_dist_reg;
                            wd.nexthop = rq_via_reg;
                            o_status = ST_UPDATED;
                        end
                        else
                            o_status = ST_KEPT;
                    end
                    else if (full)
                        o_status = ST_FULL;
                    else
                    begin
                        we = 1'b1;
                        wa = count_reg[IDX_W-1:0];
                        wd = new_entry;
                        o_slot = 5'(count_reg);
                        o_status = (rq_type_reg == REQ_LOAD) ? ST_LOADED : ST_INSERTED;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_LOST:
                    o_status = ST_LOST;
                REQ_AGE:
                    o_status = ST_AGED;
                REQ_READ:
                begin
                    o_slot = rq_idx_reg;
                    if (32'(rq_idx_reg) < 32'(count_reg))
                    begin
                        o_status = ST_READ_OK;
                        o_entry = rd_data_reg;
                    end
                    else
                        o_status = ST_BAD_IDX;
                end
                default:
                    o_status = ST_IGNORED;
            endcase
        end
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            count_reg <= '0;
            p_vld_reg <= 1'b0;
            stop_reg <= 1'b0;
            lrn_found_reg <= 1'b0;
            age_limit_reg <= AGE_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                age_limit_reg <= cfg.age_limit;
            p_vld_reg <= cmd.scan_issue;
            if (cmd.accept)
            begin
                idx_reg <= '0;
                stop_reg <= 1'b0;
                lrn_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                    idx_reg <= idx_reg + CNT_W'(1);
                if (stop_set)
                    stop_reg <= 1'b1;
                if (lrn_set)
                    lrn_found_reg <= 1'b1;
            end
            count_reg <= count_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rq_type_reg <= req_t'(req.req_type);
            rq_pfx_reg <= req.net_prefix;
            rq_len_reg <= req.prefix_len;
            rq_dist_reg <= req.route_distance;
            rq_via_reg <= req.via_addr;
            rq_idx_reg <= req.entry_index;
        end
        if (cmd.scan_issue)
            p_idx_reg <= idx_reg[IDX_W-1:0];
        if (stop_set)
            stop_slot_reg <= p_idx_reg;
        if (lrn_set)
        begin
            lrn_slot_reg <= p_idx_reg;
            lrn_entry_reg <= e;
        end
        if (cmd.finish)
        begin
            o_status_reg <= o_status;
            o_slot_reg <= o_slot;
            o_entry_reg <= o_entry;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.status = o_status_reg;
    assign rsp.slot = o_slot_reg;
    assign rsp.out_prefix = o_entry_reg.prefix;
    assign rsp.out_len = o_entry_reg.len;
    assign rsp.out_distance = o_entry_reg.distance;
    assign rsp.out_via = o_entry_reg.nexthop;
    assign rsp.out_direct = o_entry_reg.direct;
    assign rsp.entry_total = 6'(count_reg);

endmodule

// ----- hw/rtl/distance_vector_route_table.sv -----
// Distance-vector route table, top level.
// The block keeps up to TABLE_DEPTH routes in a single-port-write, registered-read
// memory and serves one request at a time. For a load, a read or an unknown request,
// and for any request while the table is empty, the sequencer goes from idle straight
// to the finish state, registers the result there once the result register is free,
// and then returns to idle to take the next one. An advertisement, a lost-neighbor
// request or an age tick walks the stored entries one per cycle through the memory read
// port, then passes the drain and finish states before its result is registered; an
// advertisement that hits a directly connected network ends its walk at that entry.
// The age_limit register may be written at any time the block is idle; its transfer
// always completes at once. The result register frees the input side as soon as the
// result has been computed, so a new request is taken while a result still waits.
// The memory is not cleared after reset; entries at or above the entry count are unused.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    dvrt_req_if.sink   req,
    dvrt_rsp_if.source rsp,
    dvrt_cfg_if.sink   cfg
);

    cmd_t  cmd;
    stat_t stat;

    // The sequencer decides when to take a request, walk the table and finish.
    dvrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the table, the merge logic and the result register.
    dvrt_path #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_path (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

// ----- hw/rtl/dvrt_checker.sv -----
// Port-level checker of the route table and its bind.
`include "assert_macros.svh"

module dvrt_checker
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [3:0]  status,
    input logic [4:0]  slot,
    input logic [31:0] out_prefix,
    input logic [31:0] out_distance,
    input logic [5:0]  entry_total
);

    `DVRT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status), "result dropped while stalled")
    `DVRT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready, "second request taken while busy")
    `DVRT_ASSERT(a_total_bound, clk, rst_n, rsp_valid |-> 32'(entry_total) <= 32'(TABLE_DEPTH), "entry count exceeds table")
    `DVRT_ASSERT(a_read_slot, clk, rst_n, (rsp_valid && status == ST_READ_OK) |-> slot < entry_total, "read beyond table")
    `DVRT_ASSERT(a_zero_contents, clk, rst_n, (rsp_valid && status != ST_READ_OK) |-> (out_prefix == 32'd0 && out_distance == 32'd0), "contents without a read")

endmodule

bind distance_vector_route_table dvrt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_dvrt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .slot         (rsp.slot),
    .out_prefix   (rsp.out_prefix),
    .out_distance (rsp.out_distance),
    .entry_total  (rsp.entry_total)
);
